FILE: src/mcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared constants, codes and types of the midpoint circle plotter.
// ----------------------------------------------------------------------------
package mcp_pkg;

  // frame buffer geometry, two pixels per word
  localparam int LINE_WORDS  = 320;
  localparam int FRAME_LINES = 480;
  localparam int FRAME_WORDS = LINE_WORDS * FRAME_LINES;
  localparam int RADIUS_BITS = 9;

  // port field widths
  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 9;
  localparam int PIX_W    = 12;
  localparam int ADDR_W   = 19;
  localparam int DATA_W   = 32;
  localparam int BE_W     = 4;
  localparam int CFG_IDX_W = 1;

  // internal widths
  localparam int OFS_W = RADIUS_BITS;
  localparam int DEC_W = RADIUS_BITS + 3;
  localparam int PT_W  = ((COORD_W > OFS_W) ? COORD_W : OFS_W) + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // pen masks and byte enables
  localparam logic [DATA_W-1:0] EVEN_MASK = 32'hFFFF00FF;
  localparam logic [DATA_W-1:0] ODD_MASK  = 32'h0000FF00;
  localparam logic [BE_W-1:0]   EVEN_BE   = 4'b1101;
  localparam logic [BE_W-1:0]   ODD_BE    = 4'b0010;

  localparam logic [DATA_W-1:0] PEN_RESET = 32'hFF80FF80;

  // input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOUR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SELECT = 1'd1;

  // point pattern of one step
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_AXIS   = 2'd1;
  localparam logic [1:0] KIND_DIAG   = 2'd2;
  localparam logic [1:0] KIND_OCTANT = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [OFS_W-1:0]   x;
    logic [OFS_W-1:0]   y;
    logic [1:0]         kind;
    logic               done;
  } step_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] pen_colour;
    logic              frame_select;
  } cfg_regs_t;

endpackage

FILE: src/mcp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp channels
// Valid/ready channels of the plotter: step items, point results, config.
// ----------------------------------------------------------------------------
interface mcp_in_if;
  import mcp_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [COORD_W-1:0]  centre_x;
  logic [COORD_W-1:0]  centre_y;
  logic [RADIUS_W-1:0] radius;

  modport source (output valid, action, centre_x, centre_y, radius, input ready);
  modport sink (input valid, action, centre_x, centre_y, radius, output ready);
endinterface

interface mcp_out_if;
  import mcp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    pixel_valid;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [ADDR_W-1:0]       word_address;
  logic [DATA_W-1:0]       write_data;
  logic [BE_W-1:0]         byte_enable;
  logic                    off_screen;
  logic                    last_of_step;
  logic                    circle_done;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, word_address, write_data,
                  byte_enable, off_screen, last_of_step, circle_done, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, word_address, write_data,
                byte_enable, off_screen, last_of_step, circle_done, output ready);
endinterface

interface mcp_cfg_if;
  import mcp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/midpoint_circle_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_plotter
// Midpoint circle outline generator for a packed YUYV frame buffer.
// ----------------------------------------------------------------------------
// Each start or advance item yields 1, 4 or 8 result beats: an octant step
// gives 8 points, an axis or diagonal step 4, a finished circle one empty
// done beat. The back end point sequencer emits one point per clock while the
// output is not stalled, and each point passes through the point and output
// registers. The front end takes an item every cycle while its 4-entry command
// queue has room. Configuration writes are always ready and take effect at
// once; no clearing pass follows reset.
module midpoint_circle_plotter (
  input  logic       clk,
  input  logic       rst,
  mcp_in_if.sink     cmd,
  mcp_out_if.source  pixel,
  mcp_cfg_if.sink    cfg
);
  import mcp_pkg::*;

  cfg_regs_t cfg_regs;
  step_cmd_t push_data, head;
  logic      push, pop, q_full, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pen_colour   <= PEN_RESET;
      cfg_regs.frame_select <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PEN_COLOUR:   cfg_regs.pen_colour   <= cfg.data;
        REG_FRAME_SELECT: cfg_regs.frame_select <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  mcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  mcp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .pixel    (pixel)
  );

endmodule

FILE: src/mcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_front
// Accepts step items, runs the midpoint decision update and classifies
// the point pattern of each step into a command for the back end.
// ----------------------------------------------------------------------------
module mcp_front (
  input  logic               clk,
  input  logic               rst,
  mcp_in_if.sink             cmd,
  input  logic               q_full,
  output logic               push,
  output mcp_pkg::step_cmd_t push_data
);
  import mcp_pkg::*;

  logic [COORD_W-1:0] held_centre_x, held_centre_y;
  logic [OFS_W-1:0]   step_x, step_y;
  logic [DEC_W-1:0]   decision;
  logic               drawing;

  logic [COORD_W-1:0] cx_next, cy_next;
  logic [OFS_W-1:0]   x_next, y_next;
  logic [DEC_W-1:0]   decision_next;
  logic               drawing_next;

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    cx_next       = held_centre_x;
    cy_next       = held_centre_y;
    x_next        = step_x;
    y_next        = step_y;
    decision_next = decision;
    drawing_next  = drawing;
    if (cmd.action == ACT_START) begin
      cx_next       = cmd.centre_x;
      cy_next       = cmd.centre_y;
      x_next        = '0;
      y_next        = OFS_W'(cmd.radius);
      decision_next = DEC_W'(1) - DEC_W'(y_next);
      drawing_next  = (y_next != '0);
    end else if (drawing) begin
      x_next = step_x + OFS_W'(1);
      // sign bit of the decision picks the east or south-east move
      if (decision[DEC_W-1]) begin
        decision_next = decision + (DEC_W'(x_next) << 1) + DEC_W'(1);
      end else begin
        y_next        = step_y - OFS_W'(1);
        decision_next = decision + ((DEC_W'(x_next) - DEC_W'(y_next)) << 1) + DEC_W'(1);
      end
      drawing_next = (x_next < y_next);
    end
  end

  always_comb begin
    push_data.cx   = cx_next;
    push_data.cy   = cy_next;
    push_data.x    = x_next;
    push_data.y    = y_next;
    push_data.done = !drawing_next;
    if (cmd.action == ACT_ADVANCE && !drawing) begin
      push_data.kind = KIND_EMPTY;
    end else if (x_next == '0) begin
      push_data.kind = KIND_AXIS;
    end else if (x_next == y_next) begin
      push_data.kind = KIND_DIAG;
    end else if (x_next < y_next) begin
      push_data.kind = KIND_OCTANT;
    end else begin
      push_data.kind = KIND_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_centre_x <= '0;
      held_centre_y <= '0;
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      drawing       <= 1'b0;
    end else if (push) begin
      held_centre_x <= cx_next;
      held_centre_y <= cy_next;
      step_x        <= x_next;
      step_y        <= y_next;
      decision      <= decision_next;
      drawing       <= drawing_next;
    end
  end

  a_drawing_order: assert property (@(posedge clk) disable iff (rst)
    drawing |-> step_x < step_y)
    else $error("drawing with x not below y");

endmodule

FILE: src/mcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_queue
// Short command queue between the step front end and the point back end.
// ----------------------------------------------------------------------------
module mcp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcp_pkg::step_cmd_t push_data,
  output logic               full,
  input  logic               pop,
  output mcp_pkg::step_cmd_t pop_data,
  output logic               empty
);
  import mcp_pkg::*;

  step_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue popped while empty");

endmodule

FILE: src/mcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_back
// Walks the symmetric points of each queued step, one per cycle while the output
// is not stalled, and forms the frame buffer word address, pen data and byte
// enables of each point.
module mcp_back (
  input  logic               clk,
  input  logic               rst,
  input  mcp_pkg::cfg_regs_t cfg_regs,
  input  mcp_pkg::step_cmd_t head,
  input  logic               q_empty,
  output logic               pop,
  mcp_out_if.source          pixel
);
  import mcp_pkg::*;

  logic [2:0] k;
  logic [2:0] k_last;
  logic       is_last;

  logic [OFS_W-1:0] dx, dy;
  logic             neg_x, neg_y;
  logic [PT_W-1:0]  px, py;

  // point stage
  logic            a_valid, a_empty, a_last, a_done;
  logic [PT_W-1:0] a_px, a_py;
  logic            a_load;

  // output register
  logic                    o_valid, o_pixel_valid, o_off, o_last, o_done;
  logic signed [PIX_W-1:0] o_px, o_py;
  logic [ADDR_W-1:0]       o_addr;
  logic [DATA_W-1:0]       o_data;
  logic [BE_W-1:0]         o_be;
  logic                    b_load;

  logic        off;
  logic [31:0] addr_full;

  assign b_load = !o_valid || pixel.ready;
  assign a_load = !a_valid || b_load;

  always_comb begin
    case (head.kind)
      KIND_AXIS:   k_last = 3'd3;
      KIND_DIAG:   k_last = 3'd3;
      KIND_OCTANT: k_last = 3'd7;
      default:     k_last = 3'd0;
    endcase
  end

  assign is_last = (k == k_last);
  assign pop     = a_load && !q_empty && is_last;

  // offset pattern of point k
  always_comb begin
    dx    = '0;
    dy    = '0;
    neg_x = 1'b0;
    neg_y = 1'b0;
    case (head.kind)
      KIND_AXIS: begin
        if (!k[1]) begin
          dy    = head.y;
          neg_y = k[0];
        end else begin
          dx    = head.y;
          neg_x = k[0];
        end
      end
      KIND_DIAG, KIND_OCTANT: begin
        if (!k[2]) begin
          dx = head.x;
          dy = head.y;
        end else begin
          dx = head.y;
          dy = head.x;
        end
        neg_x = k[0];
        neg_y = k[1];
      end
      default: begin
      end
    endcase
    px = neg_x ? PT_W'(head.cx) - PT_W'(dx) : PT_W'(head.cx) + PT_W'(dx);
    py = neg_y ? PT_W'(head.cy) - PT_W'(dy) : PT_W'(head.cy) + PT_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      k       <= '0;
    end else if (a_load) begin
      a_valid <= !q_empty;
      if (!q_empty) begin
        k <= is_last ? 3'd0 : k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && !q_empty) begin
      a_px    <= px;
      a_py    <= py;
      a_empty <= (head.kind == KIND_EMPTY);
      a_last  <= is_last;
      a_done  <= head.done || (head.kind == KIND_EMPTY);
    end
  end

  // bounds are judged on the unwrapped point
  always_comb begin
    off = a_px[PT_W-1] || a_py[PT_W-1] ||
          (32'(a_px[PT_W-2:0]) >= 32'(2 * LINE_WORDS)) ||
          (32'(a_py[PT_W-2:0]) >= 32'(FRAME_LINES));
    addr_full = (cfg_regs.frame_select ? 32'(FRAME_WORDS) : 32'd0) +
                32'(a_py[PT_W-2:0]) * 32'(LINE_WORDS) + 32'(a_px[PT_W-2:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (b_load) begin
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      o_last <= a_last;
      o_done <= a_done;
      if (a_empty) begin
        o_pixel_valid <= 1'b0;
        o_px          <= '0;
        o_py          <= '0;
        o_addr        <= '0;
        o_data        <= '0;
        o_be          <= '0;
        o_off         <= 1'b0;
      end else begin
        o_pixel_valid <= 1'b1;
        o_px          <= PIX_W'(a_px);
        o_py          <= PIX_W'(a_py);
        o_off         <= off;
        if (off) begin
          o_addr <= '0;
          o_data <= '0;
          o_be   <= '0;
        end else if (a_px[0]) begin
          o_addr <= ADDR_W'(addr_full);
          o_data <= cfg_regs.pen_colour & ODD_MASK;
          o_be   <= ODD_BE;
        end else begin
          o_addr <= ADDR_W'(addr_full);
          o_data <= cfg_regs.pen_colour & EVEN_MASK;
          o_be   <= EVEN_BE;
        end
      end
    end
  end

  assign pixel.valid        = o_valid;
  assign pixel.pixel_valid  = o_pixel_valid;
  assign pixel.pixel_x      = o_px;
  assign pixel.pixel_y      = o_py;
  assign pixel.word_address = o_addr;
  assign pixel.write_data   = o_data;
  assign pixel.byte_enable  = o_be;
  assign pixel.off_screen   = o_off;
  assign pixel.last_of_step = o_last;
  assign pixel.circle_done  = o_done;

  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_pixel_valid |-> o_last && o_done)
    else $error("empty result not marked last and done");

  a_off_no_write: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_off |-> o_be == '0 && o_pixel_valid)
    else $error("off-screen point carries byte enables");

endmodule

FILE: tb/sv/tb_midpoint_circle_plotter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_plotter
// Self-checking bench for the midpoint circle plotter. Start and advance
// items go in on the command channel. A model of the midpoint
// walk predicts every point beat: its coordinates, word address, pen data,
// byte enables and flags. Each beat is checked in order against that model.
// Pen colour and frame select change between phases, and the sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_plotter;
  import mcp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic                action;
    logic [COORD_W-1:0]  centre_x;
    logic [COORD_W-1:0]  centre_y;
    logic [RADIUS_W-1:0] radius;
  } step_item_t;

  typedef struct packed {
    logic                    pixel_valid;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [ADDR_W-1:0]       word_address;
    logic [DATA_W-1:0]       write_data;
    logic [BE_W-1:0]         byte_enable;
    logic                    off_screen;
    logic                    last_of_step;
    logic                    circle_done;
  } point_t;

  // tracks the circle walk and the points it should produce
  class circle_trace;
    point_t            pending_points[$];
    logic [DATA_W-1:0] pen;
    logic              frame;
    int                cx;
    int                cy;
    int                ofs_x;
    int                ofs_y;
    int                decision;
    bit                drawing;
    int                errors;
    int                points_checked;
    int                reports;

    function new();
      pen            = PEN_RESET;
      frame          = 1'b0;
      cx             = 0;
      cy             = 0;
      ofs_x          = 0;
      ofs_y          = 0;
      decision       = 0;
      drawing        = 1'b0;
      errors         = 0;
      points_checked = 0;
      reports        = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      case (idx)
        REG_PEN_COLOUR:   pen = val;
        REG_FRAME_SELECT: frame = val[0];
        default: ;
      endcase
    endfunction

    function void push_empty();
      point_t p;
      p              = '0;
      p.last_of_step = 1'b1;
      p.circle_done  = 1'b1;
      pending_points.push_back(p);
    endfunction

    function void push_point(input int px, input int py, input bit done, input bit last);
      point_t p;
      bit     off;
      p   = '0;
      off = (px < 0) || (px >= 2 * LINE_WORDS) || (py < 0) || (py >= FRAME_LINES);
      p.pixel_valid = 1'b1;
      p.pixel_x     = PIX_W'(px);
      p.pixel_y     = PIX_W'(py);
      if (!off) begin
        p.word_address = ADDR_W'(int'(frame) * FRAME_WORDS + py * LINE_WORDS + px / 2);
        if ((px & 1) != 0) begin
          p.write_data  = pen & ODD_MASK;
          p.byte_enable = ODD_BE;
        end else begin
          p.write_data  = pen & EVEN_MASK;
          p.byte_enable = EVEN_BE;
        end
      end
      p.off_screen   = off;
      p.last_of_step = last;
      p.circle_done  = done;
      pending_points.push_back(p);
    endfunction

    // symmetric points of the current offsets: axis, diagonal or octant
    function void plot_symmetry(input bit done);
      int xs[8];
      int ys[8];
      int n;
      n = 0;
      if (ofs_x == 0) begin
        xs[0] = cx;         ys[0] = cy + ofs_y;
        xs[1] = cx;         ys[1] = cy - ofs_y;
        xs[2] = cx + ofs_y; ys[2] = cy;
        xs[3] = cx - ofs_y; ys[3] = cy;
        n = 4;
      end else if (ofs_x <= ofs_y) begin
        xs[0] = cx + ofs_x; ys[0] = cy + ofs_y;
        xs[1] = cx - ofs_x; ys[1] = cy + ofs_y;
        xs[2] = cx + ofs_x; ys[2] = cy - ofs_y;
        xs[3] = cx - ofs_x; ys[3] = cy - ofs_y;
        n = 4;
        if (ofs_x < ofs_y) begin
          xs[4] = cx + ofs_y; ys[4] = cy + ofs_x;
          xs[5] = cx - ofs_y; ys[5] = cy + ofs_x;
          xs[6] = cx + ofs_y; ys[6] = cy - ofs_x;
          xs[7] = cx - ofs_y; ys[7] = cy - ofs_x;
          n = 8;
        end
      end
      if (n == 0) begin
        push_empty();
      end else begin
        for (int k = 0; k < n; k++) push_point(xs[k], ys[k], done, k == n - 1);
      end
    endfunction

    function void accept_step(input step_item_t it);
      int r;
      if (it.action == ACT_START) begin
        r        = int'(it.radius) & ((1 << RADIUS_BITS) - 1);
        cx       = int'(it.centre_x);
        cy       = int'(it.centre_y);
        ofs_x    = 0;
        ofs_y    = r;
        decision = 1 - r;
        drawing  = ofs_x < ofs_y;
        plot_symmetry(!drawing);
      end else if (!drawing) begin
        push_empty();
      end else begin
        ofs_x++;
        if (decision < 0) begin
          decision += 2 * ofs_x + 1;
        end else begin
          ofs_y--;
          decision += 2 * (ofs_x - ofs_y) + 1;
        end
        drawing = ofs_x < ofs_y;
        plot_symmetry(!drawing);
      end
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (reports < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        reports++;
      end
    endfunction

    function void check_point(input point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS)
          $display("%0t: unexpected point beat, expected none actual x %0d y %0d",
                   $time, got.pixel_x, got.pixel_y);
        reports++;
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      compare("pixel_valid", want.pixel_valid, got.pixel_valid);
      compare("pixel_x", want.pixel_x, got.pixel_x);
      compare("pixel_y", want.pixel_y, got.pixel_y);
      compare("word_address", want.word_address, got.word_address);
      compare("write_data", want.write_data, got.write_data);
      compare("byte_enable", want.byte_enable, got.byte_enable);
      compare("off_screen", want.off_screen, got.off_screen);
      compare("last_of_step", want.last_of_step, got.last_of_step);
      compare("circle_done", want.circle_done, got.circle_done);
    endfunction
  endclass

  logic clk;
  logic rst;

  mcp_in_if  cmd_if ();
  mcp_out_if pixel_if ();
  mcp_cfg_if cfg_if ();

  midpoint_circle_plotter i_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .pixel (pixel_if),
    .cfg   (cfg_if)
  );

  circle_trace trace;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          items_sent;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d points outstanding", $time, trace.pending_points.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // point sink: check accepted beats, then pick ready for the next cycle
  initial begin
    point_t got;
    pixel_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) begin
        got.pixel_valid  = pixel_if.pixel_valid;
        got.pixel_x      = pixel_if.pixel_x;
        got.pixel_y      = pixel_if.pixel_y;
        got.word_address = pixel_if.word_address;
        got.write_data   = pixel_if.write_data;
        got.byte_enable  = pixel_if.byte_enable;
        got.off_screen   = pixel_if.off_screen;
        got.last_of_step = pixel_if.last_of_step;
        got.circle_done  = pixel_if.circle_done;
        trace.check_point(got);
      end
      pixel_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // leaves valid high after the beat; settle() drops it
  task automatic send_item(input step_item_t it);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && gap < 24 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.action   <= it.action;
    cmd_if.centre_x <= it.centre_x;
    cmd_if.centre_y <= it.centre_y;
    cmd_if.radius   <= it.radius;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
    trace.accept_step(it);
    items_sent++;
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (trace.pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_pen_and_frame(input logic [DATA_W-1:0] pen, input logic frame);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_PEN_COLOUR;
    cfg_if.data  <= pen;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    trace.write_reg(REG_PEN_COLOUR, pen);
    cfg_if.index <= REG_FRAME_SELECT;
    cfg_if.data  <= DATA_W'(frame);
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    trace.write_reg(REG_FRAME_SELECT, DATA_W'(frame));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic step_item_t make_item(input logic act, input int x, input int y,
                                           input int r);
    step_item_t it;
    it.action   = act;
    it.centre_x = COORD_W'(x);
    it.centre_y = COORD_W'(y);
    it.radius   = RADIUS_W'(r);
    return it;
  endfunction

  function automatic step_item_t start_item(input bit big);
    int x;
    int y;
    if ($urandom_range(0, 1) == 1) begin
      x = $urandom_range(0, 2 * LINE_WORDS - 1);
      y = $urandom_range(0, FRAME_LINES - 1);
    end else begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(0, 1023);
    end
    return make_item(ACT_START, x, y, big ? $urandom_range(100, 511) : $urandom_range(0, 24));
  endfunction

  // centre and radius are ignored on advance, so they carry noise
  function automatic step_item_t advance_item();
    return make_item(ACT_ADVANCE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 511));
  endfunction

  task automatic directed_items();
    send_item(make_item(ACT_ADVANCE, 0, 0, 0));       // advance before any circle
    send_item(make_item(ACT_START, 0, 0, 0));         // zero radius at origin
    send_item(make_item(ACT_ADVANCE, 1023, 1023, 511));
    send_item(make_item(ACT_START, 1023, 1023, 511)); // far corner, all off screen
    send_item(make_item(ACT_ADVANCE, 0, 0, 0));
    send_item(make_item(ACT_ADVANCE, 0, 0, 0));
    send_item(make_item(ACT_START, 320, 240, 3));     // abandons the big circle
    repeat (4) send_item(make_item(ACT_ADVANCE, 0, 0, 0));
    send_item(make_item(ACT_START, 639, 479, 1));     // screen edge, odd column
    repeat (2) send_item(make_item(ACT_ADVANCE, 0, 0, 0));
    send_item(make_item(ACT_START, 1, 1, 2));         // negative coordinates
    repeat (3) send_item(make_item(ACT_ADVANCE, 0, 0, 0));
    send_item(make_item(ACT_START, 0, 1023, 511));
    send_item(make_item(ACT_ADVANCE, 1023, 0, 0));
    send_item(make_item(ACT_START, 4, 6, 5));
    repeat (2) send_item(make_item(ACT_ADVANCE, 0, 0, 0));
  endtask

  // mostly whole circles with random content, some cut short, some noise
  task automatic random_items(input int count);
    int goal;
    int pick;
    int steps;
    int cap;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 4) settle();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_item(start_item(pick < 3));
        cap   = (pick < 3) ? 40 : 1000;
        steps = 0;
        while (trace.drawing && steps < cap) begin
          send_item(advance_item());
          steps++;
        end
        repeat ($urandom_range(0, 2)) send_item(advance_item());
      end else if (pick < 92) begin
        send_item(start_item(1'b0));
        repeat ($urandom_range(0, 3)) send_item(advance_item());
      end else begin
        send_item(make_item(logic'($urandom_range(0, 1)), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 511)));
      end
    end
  endtask

  initial begin
    trace              = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    items_sent         = 0;
    rst                = 1'b1;
    cmd_if.valid       = 1'b0;
    cmd_if.action      = ACT_START;
    cmd_if.centre_x    = '0;
    cmd_if.centre_y    = '0;
    cmd_if.radius      = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_PEN_COLOUR;
    cfg_if.data        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, no idling on either side
    directed_items();
    random_items(80);
    settle();

    load_pen_and_frame(32'hFFFFFFFF, 1'b1);
    sender_idle_pct = 50;
    random_items(110);
    settle();

    load_pen_and_frame(32'h00000000, 1'b0);
    sender_idle_pct    = 0;
    receiver_stall_pct = 50;
    random_items(55);
    settle();
    random_items(55);
    settle();

    load_pen_and_frame($urandom, 1'b1);
    sender_idle_pct    = 15;
    receiver_stall_pct = 15;
    random_items(110);
    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d step items and %0d point beats", items_sent, trace.points_checked);
    $display("pen at reset, all ones, all zeros and random; both frames; four idle mixes");
    if (trace.errors == 0 && trace.pending_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d points never arrived", trace.errors,
               trace.pending_points.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
